FILE: rtl/core/pliu_pkg.sv
// ---------------------------------------------------------------------------
// pliu_pkg: shared types and constants of the positional list unit
// request and response structs, opcodes, status codes and list geometry
// ---------------------------------------------------------------------------
`default_nettype none

package pliu_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = 5;
    localparam int POS_W      = 5;
    localparam int WORD_W     = 32;
    localparam int OP_W       = 4;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 4'd0,
        OP_ERASE      = 4'd1,
        OP_PUSH_BACK  = 4'd2,
        OP_PUSH_FRONT = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_POP_FRONT  = 4'd5,
        OP_CLEAR      = 4'd6,
        OP_READ       = 4'd7,
        OP_READ_LAST  = 4'd8,
        OP_DUMP       = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        STATE_IDLE = 1'b0,
        STATE_DUMP = 1'b1
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        word_t            value;
    } req_t;

    typedef struct packed {
        word_t            data;
        logic [CNT_W-1:0] count;
        status_t          status;
        logic             last;
    } rsp_t;

    // shift command broadcast to the whole chain
    typedef struct packed {
        logic             ins;
        logic             ers;
        logic [IDX_W-1:0] pos;
    } shift_cmd_t;

    // per-cell view of the shift command
    typedef struct packed {
        logic ins;
        logic ers;
        logic here;
        logic above;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/pliu_cell.sv
// ---------------------------------------------------------------------------
// pliu_cell: one list entry
// holds a word, loads the new word or a neighbor's word on insert and erase
// ---------------------------------------------------------------------------
`default_nettype none

module pliu_cell
    import pliu_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire word_t     new_word,
    input  wire word_t     left_word,
    input  wire word_t     right_word,
    output word_t          word
);

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        priority if (ctl.ins && ctl.here)
        begin
            word_next = new_word;
        end
        else if (ctl.ins && ctl.above)
        begin
            word_next = left_word;     // move up
        end
        else if (ctl.ers && (ctl.here || ctl.above))
        begin
            word_next = right_word;    // move down
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pliu_chain.sv
// ---------------------------------------------------------------------------
// pliu_chain: row of list cells
// each cell trades words with its neighbors; one registered-side read port
// ---------------------------------------------------------------------------
`default_nettype none

module pliu_chain
    import pliu_pkg::*;
(
    input  wire logic             clk,
    input  wire shift_cmd_t       cmd,
    input  wire word_t            new_word,
    input  wire logic [IDX_W-1:0] rd_addr,
    output word_t                 rd_word
);

    word_t words [LIST_DEPTH];

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        cell_ctl_t ctl;
        word_t     left_word;
        word_t     right_word;

        assign ctl.ins   = cmd.ins;
        assign ctl.ers   = cmd.ers;
        assign ctl.here  = (IDX_W'(i) == cmd.pos);
        assign ctl.above = (IDX_W'(i) > cmd.pos);

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_left
            assign left_word = words[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_end
            assign right_word = '0;
        end
        else
        begin : g_right
            assign right_word = words[i+1];
        end

        pliu_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .new_word   (new_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    assign rd_word = words[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/core/positional_list_insert_erase_unit.sv
// ---------------------------------------------------------------------------
// positional_list_insert_erase_unit: ordered list of signed words
// insert/erase at a position, push/pop at either end, clear, read, dump
// ---------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req (opcode, position, value)
//   response channel: rsp_valid / rsp_stall / rsp (data, count, status, last)
//   a request is taken at a clock edge with valid high and stall low
//   every command except a non-empty dump gives one response, presented
//   from the response register, which is loaded as the request is taken
//   commands other than dump are taken one per cycle unless stalled: the
//   cell row shifts in parallel, so an insert or erase finishes in that cycle
//   a dump of n entries gives n responses, one per cycle unless stalled,
//   the final one marked by last; req_stall stays high while it streams
//   rejected commands (full, empty, bad position) leave the list unchanged
//   and report the reason in status with data zero
//   reset empties the list; no clearing pass, entries past the count are
//   never read
//   when rsp_stall holds the response register, req_stall rises the same
//   cycle and the pending response stays put until taken
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_erase_unit
    import pliu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,

    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    // control state
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    // handshake helpers
    logic             out_free;
    logic             req_take;
    logic             list_full;
    logic             list_empty;
    logic             dump_start;
    logic             dump_final;
    logic             load_rsp;
    logic [CNT_W-1:0] count_less_one;

    // chain interface
    shift_cmd_t       shift_cmd;
    logic [IDX_W-1:0] rd_addr;
    word_t            rd_word;

    // response register empties or is being taken this cycle
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg == STATE_DUMP) || !out_free;
    assign req_take   = req_valid && !req_stall;

    assign list_full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign list_empty     = (count_reg == '0);
    assign count_less_one = count_reg - CNT_W'(1);

    assign dump_start = req_take && (req.opcode == OP_DUMP) && !list_empty;
    assign dump_final = ({1'b0, idx_reg} == count_less_one);

    // read address: dump index, last entry on read-last, else read position
    always_comb
    begin
        if (state_reg == STATE_DUMP)
        begin
            rd_addr = idx_reg;
        end
        else if (req.opcode == OP_READ_LAST)
        begin
            rd_addr = count_less_one[IDX_W-1:0];
        end
        else
        begin
            rd_addr = req.position[IDX_W-1:0];
        end
    end

    pliu_chain u_chain (
        .clk      (clk),
        .cmd      (shift_cmd),
        .new_word (req.value),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = STATE_DUMP;
                end
            end
            STATE_DUMP:
            begin
                if (out_free && dump_final)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    // command decode, shift command and response
    always_comb
    begin
        shift_cmd       = '0;
        count_next      = count_reg;
        idx_next        = idx_reg;
        load_rsp        = 1'b0;
        rsp_next        = '0;
        rsp_next.status = STATUS_OK;
        rsp_next.last   = 1'b1;

        unique case (state_reg)
            STATE_IDLE:
            begin
                idx_next = '0;
                if (req_take)
                begin
                    load_rsp = !dump_start;
                    unique case (req.opcode)
                        OP_INSERT:
                        begin
                            if (list_full)
                                rsp_next.status = STATUS_FULL;
                            else if (req.position > count_reg)
                                rsp_next.status = STATUS_RANGE;
                            else
                            begin
                                shift_cmd.ins = 1'b1;
                                shift_cmd.pos = req.position[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else if (req.position >= count_reg)
                                rsp_next.status = STATUS_RANGE;
                            else
                            begin
                                shift_cmd.ers = 1'b1;
                                shift_cmd.pos = req.position[IDX_W-1:0];
                                count_next    = count_less_one;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (list_full)
                                rsp_next.status = STATUS_FULL;
                            else
                            begin
                                shift_cmd.ins = 1'b1;
                                shift_cmd.pos = count_reg[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (list_full)
                                rsp_next.status = STATUS_FULL;
                            else
                            begin
                                shift_cmd.ins = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else
                            begin
                                shift_cmd.ers = 1'b1;
                                shift_cmd.pos = count_less_one[IDX_W-1:0];
                                count_next    = count_less_one;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else
                            begin
                                shift_cmd.ers = 1'b1;
                                count_next    = count_less_one;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_READ:
                        begin
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else if (req.position >= count_reg)
                                rsp_next.status = STATUS_RANGE;
                            else
                                rsp_next.data = rd_word;
                        end
                        OP_READ_LAST:
                        begin
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                            else
                                rsp_next.data = rd_word;
                        end
                        OP_DUMP:
                        begin
                            // non-empty dump streams from the dump state
                            if (list_empty)
                                rsp_next.status = STATUS_EMPTY;
                        end
                        default:
                        begin
                            // unused opcodes: plain acknowledge
                        end
                    endcase
                end
                rsp_next.count = count_next;
            end
            STATE_DUMP:
            begin
                load_rsp       = out_free;
                rsp_next.data  = rd_word;
                rsp_next.count = count_reg;
                rsp_next.last  = dump_final;
                if (out_free)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count never passes the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond depth");

    // the list count does not change while a dump streams
    a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == STATE_DUMP |=> count_reg == $past(count_reg))
        else $error("count changed during dump");

    // dump index stays inside the list
    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == STATE_DUMP |-> {1'b0, idx_reg} < count_reg)
        else $error("dump index past the count");

    // a rejected command gives one final response with zero data
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != STATUS_OK
            |-> rsp_reg.last && rsp_reg.data == '0)
        else $error("malformed reject response");

endmodule

`default_nettype wire

FILE: dv/tb_positional_list_insert_erase_unit.sv
// ---------------------------------------------------------------------------
// tb_positional_list_insert_erase_unit: self-checking bench for the list unit
// a directed table of corner requests, then random grow, shrink and mixed
// traffic; every response is checked against a local model of the list
// or a pinned row; random sender gaps and receiver stalls on both channels
// ---------------------------------------------------------------------------
module tb_positional_list_insert_erase_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import pliu_pkg::*;

    // opcodes the unit does not define, answered as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED_MIN = 4'd10;
    localparam logic [OP_W-1:0] OP_UNUSED_MAX = 4'd15;

    localparam int DIR_N        = 24;
    localparam int RANDOM_ITEMS = 236;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIX
    } traffic_mode_t;

    // one row of the directed script; pinned rows carry a hand-written response
    typedef struct {
        req_t cmd;
        bit   pinned;
        rsp_t want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    positional_list_insert_erase_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // list model: own copy of the entries and the count
    // ------------------------------------------------------------------
    word_t       list_words [LIST_DEPTH];
    int unsigned list_count = 0;
    rsp_t        pending_rsps [$];

    script_row_t script [DIR_N];

    // bookkeeping for the closing summary
    int unsigned errors        = 0;
    int unsigned accepted      = 0;
    int unsigned checked       = 0;
    int unsigned dumps         = 0;
    int unsigned deepest       = 0;
    int unsigned status_seen [4];

    // queue one expected response, count taken after the command
    function automatic void expect_rsp(word_t d, status_t st, logic lst);
        rsp_t e;
        e.data   = d;
        e.count  = list_count[CNT_W-1:0];
        e.status = st;
        e.last   = lst;
        pending_rsps.insert(pending_rsps.size(), e);
        status_seen[st]++;
    endfunction

    // full check comes before the position check
    function automatic status_t list_insert(int unsigned at, word_t w);
        if (list_count >= LIST_DEPTH)
            return STATUS_FULL;
        if (at > list_count)
            return STATUS_RANGE;
        for (int unsigned i = list_count; i > at; i--)
            list_words[i] = list_words[i-1];
        list_words[at] = w;
        list_count++;
        return STATUS_OK;
    endfunction

    function automatic status_t list_erase(int unsigned at);
        if (list_count == 0)
            return STATUS_EMPTY;
        if (at >= list_count)
            return STATUS_RANGE;
        for (int unsigned i = at; i + 1 < list_count; i++)
            list_words[i] = list_words[i+1];
        list_count--;
        return STATUS_OK;
    endfunction

    // apply one accepted request to the model and queue its responses
    function automatic void predict_list(req_t r);
        status_t     st;
        word_t       rd;
        int unsigned at;
        st = STATUS_OK;
        rd = '0;
        at = r.position;
        case (r.opcode)
            OP_INSERT:     st = list_insert(at, r.value);
            OP_ERASE:      st = list_erase(at);
            OP_PUSH_BACK:  st = list_insert(list_count, r.value);
            OP_PUSH_FRONT: st = list_insert(0, r.value);
            OP_POP_BACK:   st = list_erase(list_count == 0 ? 0 : list_count - 1);
            OP_POP_FRONT:  st = list_erase(0);
            OP_CLEAR:      list_count = 0;
            OP_READ:
            begin
                if (list_count == 0)
                    st = STATUS_EMPTY;
                else if (at >= list_count)
                    st = STATUS_RANGE;
                else
                    rd = list_words[at];
            end
            OP_READ_LAST:
            begin
                if (list_count == 0)
                    st = STATUS_EMPTY;
                else
                    rd = list_words[list_count-1];
            end
            OP_DUMP:
            begin
                dumps++;
                if (list_count == 0)
                    st = STATUS_EMPTY;
                else
                begin
                    // one response per entry, last on the final one
                    for (int unsigned i = 0; i < list_count; i++)
                        expect_rsp(list_words[i], STATUS_OK, i + 1 == list_count);
                    return;
                end
            end
            default: ;  // undefined opcode: no change, plain ok response
        endcase
        expect_rsp(rd, st, 1'b1);
        if (list_count > deepest)
            deepest = list_count;
    endfunction

    // ------------------------------------------------------------------
    // monitor: check responses, then model each accepted request
    // both handshakes are sampled with their pre-edge values
    // ------------------------------------------------------------------
    rsp_t oldest;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                checked++;
                if (pending_rsps.size() == 0)
                begin
                    errors++;
                    $error("unexpected response: data %0d count %0d status %0d last %0b",
                           rsp.data, rsp.count, rsp.status, rsp.last);
                end
                else
                begin
                    oldest = pending_rsps[0];
                    pending_rsps.delete(0);
                    if (rsp.data !== oldest.data)
                    begin
                        errors++;
                        $error("data: expected %0d, got %0d", oldest.data, rsp.data);
                    end
                    if (rsp.count !== oldest.count)
                    begin
                        errors++;
                        $error("count: expected %0d, got %0d", oldest.count, rsp.count);
                    end
                    if (rsp.status !== oldest.status)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", oldest.status, rsp.status);
                    end
                    if (rsp.last !== oldest.last)
                    begin
                        errors++;
                        $error("last: expected %0b, got %0b", oldest.last, rsp.last);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_list(req);
                // pinned script rows replace the model's answer with the typed one
                if (accepted < DIR_N && script[accepted].pinned)
                    pending_rsps[pending_rsps.size() - 1] = script[accepted].want;
                accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern switches between quiet, light, heavy and periodic
    // ------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_left % 8) < 5;
        endcase
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    // hold the request until taken, then maybe open a gap
    task automatic send_request(input req_t r);
        int unsigned gap;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop sending until every queued response is back
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsps.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic add_row(input int idx, input logic [OP_W-1:0] op,
                           input logic [POS_W-1:0] pos, input word_t val,
                           input bit pin, input word_t d,
                           input logic [CNT_W-1:0] cnt, input status_t st);
        script[idx].cmd.opcode   = op;
        script[idx].cmd.position = pos;
        script[idx].cmd.value    = val;
        script[idx].pinned       = pin;
        script[idx].want.data    = d;
        script[idx].want.count   = cnt;
        script[idx].want.status  = st;
        script[idx].want.last    = 1'b1;
    endtask

    // random request shaped by traffic mode; positions mostly up to the count
    function automatic req_t random_request(traffic_mode_t m);
        req_t        r;
        int unsigned roll;
        int unsigned prow;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       r.value = 32'h7fff_ffff;
            1:       r.value = 32'h8000_0000;
            2:       r.value = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
            default: r.value = $urandom;
        endcase
        prow = $urandom_range(0, 99);
        if (prow < 80)
            r.position = POS_W'($urandom_range(0, list_count));
        else if (prow < 95)
            r.position = POS_W'($urandom_range(0, LIST_DEPTH));
        else
            r.position = POS_W'($urandom_range(LIST_DEPTH + 1, 31));
        roll = $urandom_range(0, 99);
        case (m)
            MODE_GROW:
            begin
                if      (roll < 35) r.opcode = OP_PUSH_BACK;
                else if (roll < 60) r.opcode = OP_PUSH_FRONT;
                else if (roll < 80) r.opcode = OP_INSERT;
                else if (roll < 86) r.opcode = OP_READ;
                else if (roll < 90) r.opcode = OP_DUMP;
                else if (roll < 93) r.opcode = OP_READ_LAST;
                else if (roll < 96) r.opcode = OP_ERASE;
                else if (roll < 98) r.opcode = OP_POP_BACK;
                else r.opcode = OP_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
            end
            MODE_SHRINK:
            begin
                if      (roll < 25) r.opcode = OP_POP_BACK;
                else if (roll < 50) r.opcode = OP_POP_FRONT;
                else if (roll < 75) r.opcode = OP_ERASE;
                else if (roll < 82) r.opcode = OP_READ;
                else if (roll < 88) r.opcode = OP_DUMP;
                else if (roll < 91) r.opcode = OP_READ_LAST;
                else if (roll < 95) r.opcode = OP_PUSH_BACK;
                else if (roll < 97) r.opcode = OP_CLEAR;
                else r.opcode = OP_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
            end
            default:
            begin
                if (roll < 3)
                    r.opcode = OP_W'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
                else
                begin
                    r.opcode = OP_W'($urandom_range(OP_INSERT, OP_DUMP));
                    // keep clear rare so the list has content to work on
                    if (r.opcode == OP_CLEAR && roll > 8)
                        r.opcode = OP_READ;
                end
            end
        endcase
        return r;
    endfunction

    initial
    begin
        traffic_mode_t mode;
        int unsigned   sent;
        int unsigned   ep_len;
        int unsigned   tail;
        int unsigned   episodes;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // empty-list rejects, bad positions, extremes, undefined opcode
        add_row( 0, OP_READ_LAST,  5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 1, OP_DUMP,       5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 2, OP_POP_FRONT,  5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 3, OP_POP_BACK,   5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 4, OP_ERASE,      5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 5, OP_READ,       5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);
        add_row( 6, OP_INSERT,     5'd1,  32'sd5,      1, 32'sd0, 5'd0, STATUS_RANGE);
        add_row( 7, OP_PUSH_BACK,  5'd0,  32'h7fffffff, 1, 32'sd0, 5'd1, STATUS_OK);
        add_row( 8, OP_PUSH_FRONT, 5'd0,  32'h80000000, 1, 32'sd0, 5'd2, STATUS_OK);
        add_row( 9, OP_INSERT,     5'd1,  -32'sd1,     1, 32'sd0, 5'd3, STATUS_OK);
        add_row(10, OP_INSERT,     5'd4,  32'sd9,      1, 32'sd0, 5'd3, STATUS_RANGE);
        add_row(11, OP_READ,       5'd0,  32'sd0,      1, 32'h80000000, 5'd3, STATUS_OK);
        add_row(12, OP_READ,       5'd3,  32'sd0,      1, 32'sd0, 5'd3, STATUS_RANGE);
        add_row(13, OP_READ,       5'd31, 32'sd0,      1, 32'sd0, 5'd3, STATUS_RANGE);
        add_row(14, OP_ERASE,      5'd31, 32'sd0,      1, 32'sd0, 5'd3, STATUS_RANGE);
        add_row(15, OP_READ_LAST,  5'd0,  32'sd0,      1, 32'h7fffffff, 5'd3, STATUS_OK);
        add_row(16, OP_UNUSED_MAX, 5'd31, -32'sd1,     1, 32'sd0, 5'd3, STATUS_OK);
        // from here the model answers, apart from the pinned rows at the end
        add_row(17, OP_INSERT,     5'd0,  32'h5a5a5a5a, 0, 32'sd0, 5'd0, STATUS_OK);
        add_row(18, OP_DUMP,       5'd0,  32'sd0,      0, 32'sd0, 5'd0, STATUS_OK);
        add_row(19, OP_ERASE,      5'd1,  32'sd0,      0, 32'sd0, 5'd0, STATUS_OK);
        add_row(20, OP_POP_FRONT,  5'd0,  32'sd0,      0, 32'sd0, 5'd0, STATUS_OK);
        add_row(21, OP_POP_BACK,   5'd0,  32'sd0,      0, 32'sd0, 5'd0, STATUS_OK);
        add_row(22, OP_CLEAR,      5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_OK);
        add_row(23, OP_DUMP,       5'd0,  32'sd0,      1, 32'sd0, 5'd0, STATUS_EMPTY);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_request(script[i].cmd);

        // let everything from the directed part come back before random traffic
        hold_until_drained();

        // random episodes: grow to full and probe, shrink to empty and probe, mix
        sent     = 0;
        episodes = 0;
        mode     = MODE_GROW;
        while (sent < RANDOM_ITEMS)
        begin
            tail   = 0;
            ep_len = 0;
            while (ep_len < 40 && tail < 3 && sent < RANDOM_ITEMS)
            begin
                send_request(random_request(mode));
                sent++;
                ep_len++;
                if ((mode == MODE_GROW && list_count == LIST_DEPTH) ||
                    (mode == MODE_SHRINK && list_count == 0) ||
                    (mode == MODE_MIX && ep_len >= 20))
                    tail++;
            end
            episodes++;
            if (mode == MODE_SHRINK && episodes < 6)
                hold_until_drained();
            case ($urandom_range(0, 3))
                0:       mode = MODE_SHRINK;
                1:       mode = MODE_MIX;
                default: mode = (list_count < LIST_DEPTH / 2) ? MODE_GROW : MODE_SHRINK;
            endcase
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d dumps), %0d responses, list depth up to %0d",
                 accepted, dumps, checked, deepest);
        $display("rejects seen: full %0d, empty %0d, bad position %0d",
                 status_seen[STATUS_FULL], status_seen[STATUS_EMPTY],
                 status_seen[STATUS_RANGE]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
